// ===== hw/rtl/u8u16_pkg.sv =====
// Package: shared types and constants of the UTF-8 to UTF-16 decoder.
`default_nettype none
package u8u16_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int CP_W   = 21;
  localparam int UNIT_W = 16;

  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [UNIT_W-1:0] unit_t;

  // code point handed from the front end to the queue
  typedef struct packed {
    logic valid;
    cp_t  cp;
  } cp_push_t;

  localparam cp_t   SUPP_BASE    = 21'h010000;
  localparam unit_t SURR_HI_BASE = 16'hD800;
  localparam unit_t SURR_LO_BASE = 16'hDC00;
  localparam logic [9:0] SURR_LO_MASK = 10'h3FF;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

endpackage
`default_nettype wire

// ===== hw/rtl/u8u16_front.sv =====
// Front end: takes UTF-8 bytes, assembles code points, pushes finished ones.
`default_nettype none
module u8u16_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 take,
  input  wire logic [7:0]           byte_in,
  input  wire logic                 last_byte,
  output u8u16_pkg::cp_push_t       emit
);

  localparam logic [1:0] NEED_NONE  = 2'd0;
  localparam logic [1:0] NEED_ONE   = 2'd1;
  localparam logic [1:0] NEED_TWO   = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  u8u16_pkg::cp_t partial;
  u8u16_pkg::cp_t partial_next;
  logic [1:0]     need;
  logic [1:0]     need_next;

  logic           is_cont;
  u8u16_pkg::cp_t shifted;

  assign is_cont = (byte_in & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_TAG;
  assign shifted = {partial[u8u16_pkg::CP_W-7:0], byte_in[5:0]};

  always_comb begin
    partial_next = '0;
    need_next    = NEED_NONE;
    emit.valid   = 1'b0;
    emit.cp      = '0;
    if (need != NEED_NONE && is_cont) begin
      need_next = need - 2'd1;
      if (need == NEED_ONE) begin
        emit.valid = 1'b1;
        emit.cp    = shifted;
      end else begin
        partial_next = shifted;
      end
    end else begin
      // broken sequence: pending bits are dropped, byte read as a lead
      if (!byte_in[7]) begin
        emit.valid = 1'b1;
        emit.cp    = u8u16_pkg::CP_W'(byte_in);
      end else if (!byte_in[6]) begin
        // stray continuation, dropped
      end else if (!byte_in[5]) begin
        partial_next = u8u16_pkg::CP_W'(byte_in[4:0]);
        need_next    = NEED_ONE;
      end else if (!byte_in[4]) begin
        partial_next = u8u16_pkg::CP_W'(byte_in[3:0]);
        need_next    = NEED_TWO;
      end else if (!byte_in[3]) begin
        partial_next = u8u16_pkg::CP_W'(byte_in[2:0]);
        need_next    = NEED_THREE;
      end else begin
        // invalid lead, dropped
      end
    end
    if (last_byte) begin
      partial_next = '0;
      need_next    = NEED_NONE;
    end
    if (!take) begin
      emit.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      need    <= NEED_NONE;
    end else if (take) begin
      partial <= partial_next;
      need    <= need_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/u8u16_queue.sv =====
// Short queue of finished code points between front and back ends.
`default_nettype none
module u8u16_queue #(
  parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire u8u16_pkg::cp_push_t  wr,
  input  wire logic                 rd,
  output u8u16_pkg::cp_t            rd_data,
  output logic                      q_empty,
  output logic                      q_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  u8u16_pkg::cp_t slots [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           do_wr;
  logic           do_rd;

  assign q_empty = count == '0;
  assign q_full  = count == CW'(DEPTH);
  assign do_wr   = wr.valid && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr.cp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == LAST_SLOT) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == LAST_SLOT) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/u8u16_back.sv =====
// Back end: turns code points into UTF-16 words, splitting surrogate pairs.
`default_nettype none
module u8u16_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_empty,
  input  wire u8u16_pkg::cp_t       q_data,
  output logic                      q_rd,
  input  wire logic                 pop,
  output logic                      empty,
  output u8u16_pkg::unit_t          code_unit,
  output logic                      last_of_run
);

  logic             out_valid;
  u8u16_pkg::unit_t out_unit;
  logic             out_last;
  logic             lo_pend;
  u8u16_pkg::unit_t lo_unit;

  logic             adv;
  logic             is_supp;
  u8u16_pkg::cp_t   cp_off;
  u8u16_pkg::unit_t hi_word;
  u8u16_pkg::unit_t lo_word;

  assign adv     = !out_valid || pop;
  assign q_rd    = adv && !lo_pend && !q_empty;
  assign is_supp = q_data >= u8u16_pkg::SUPP_BASE;
  assign cp_off  = q_data - u8u16_pkg::SUPP_BASE;
  assign hi_word = u8u16_pkg::SURR_HI_BASE + u8u16_pkg::UNIT_W'(cp_off[u8u16_pkg::CP_W-1:10]);
  assign lo_word = u8u16_pkg::SURR_LO_BASE
                 + u8u16_pkg::UNIT_W'(cp_off[9:0] & u8u16_pkg::SURR_LO_MASK);

  assign empty       = !out_valid;
  assign code_unit   = out_unit;
  assign last_of_run = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      lo_pend   <= 1'b0;
    end else if (adv) begin
      if (lo_pend) begin
        out_valid <= 1'b1;
        lo_pend   <= 1'b0;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        lo_pend   <= is_supp;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (lo_pend) begin
        out_unit <= lo_unit;
        out_last <= 1'b1;
      end else if (is_supp) begin
        out_unit <= hi_word;
        out_last <= 1'b0;
        lo_unit  <= lo_word;
      end else begin
        out_unit <= q_data[u8u16_pkg::UNIT_W-1:0];
        out_last <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/utf8_to_utf16_decoder.sv =====
// Top level: UTF-8 byte stream in, UTF-16 word stream out.
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ----------------------------
//  bytes    in   push / full        byte_in[7:0], last_byte
//  words    out  empty / pop        code_unit[15:0], last_of_run
//
// Rates: one byte per cycle in while full is low; one word per cycle
//   out while pop is high and words are ready. A code point of 0x10000 or
//   above gives two words; the queue is not read while the low one waits.
// Path: a completed code point is queued, then turned into the output word.
// Reset: rst is synchronous; it clears the pending sequence, the code point
//   queue and the output word.
// Stalls: full rises only when the code point queue holds QUEUE_DEPTH
//   entries; the front end keeps taking bytes while the output word waits.
`default_nettype none
module utf8_to_utf16_decoder #(
  parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  byte_in,
  input  wire logic        last_byte,
  input  wire logic        pop,
  output logic             empty,
  output logic [15:0]      code_unit,
  output logic             last_of_run
);

  u8u16_pkg::cp_push_t emit;
  u8u16_pkg::cp_t      q_data;
  logic                q_empty;
  logic                q_full;
  logic                q_rd;
  logic                take;

  // a byte is taken whenever the queue has room, finished code point or not
  assign full = q_full;
  assign take = push && !q_full;

  u8u16_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .byte_in   (byte_in),
    .last_byte (last_byte),
    .emit      (emit)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (emit),
    .rd      (q_rd),
    .rd_data (q_data),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  // back end owns the output register; the low surrogate sits beside it
  u8u16_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .code_unit   (code_unit),
    .last_of_run (last_of_run)
  );

`ifndef SYNTHESIS
  // a high surrogate taken is followed at once by its low half
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_of_run) |=>
      (!empty && last_of_run && code_unit[15:10] == 6'b110111))
    else $error("low surrogate did not follow high surrogate");

  // only surrogate halves can leave last_of_run low
  a_mid_is_surr: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last_of_run) |-> (code_unit[15:11] == 5'b11011))
    else $error("non-final word is not a surrogate");

  // queue full means code points are waiting
  a_full_has_data: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_empty)
    else $error("queue full while empty");

  // after reset nothing is pending on either side
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("reset did not clear the block");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for the UTF-8 to UTF-16 decoder: byte stimulus, word predictor and checker.
`timescale 1ns / 100ps
module testbench;

  // run shape
  localparam int RANDOM_BYTES     = 800;  // some of these are dropped by the block
  localparam int CALM_TAIL_BYTES  = 150;  // last stretch with no idling on either side
  localparam int LONG_HOLD_CYCLES = 300;  // receiver stall that backs the block up
  localparam int WATCHDOG_LIMIT   = 2000; // cycles with no handshake at all
  localparam int DRAIN_CYCLES     = 8;    // margin after the last expected word is checked
  localparam int MAX_REPORTS      = 10;

  // UTF-8 lead byte bases (prefix bits only)
  localparam logic [7:0] LEAD2_BASE = 8'hC0;
  localparam logic [7:0] LEAD3_BASE = 8'hE0;
  localparam logic [7:0] LEAD4_BASE = 8'hF0;
  localparam logic [7:0] BAD_LEAD   = 8'hF8;

  typedef struct packed {
    u8u16_pkg::unit_t unit;
    logic             last;
  } utf16_word_t;

  // Tracks the decoder state on the side and holds the words still owed by the block.
  class utf16_scoreboard;
    u8u16_pkg::cp_t partial_cp;
    logic [1:0]     conts_left;
    utf16_word_t    expected_words[$];
    int             fails;
    int             words_checked;
    int             pairs_seen;
    int             cut_by_end;

    function new();
      partial_cp    = '0;
      conts_left    = '0;
      fails         = 0;
      words_checked = 0;
      pairs_seen    = 0;
      cut_by_end    = 0;
    endfunction

    // one code point becomes one word, or a surrogate pair above the BMP
    function void queue_codepoint(u8u16_pkg::cp_t cp);
      u8u16_pkg::cp_t   offset;
      u8u16_pkg::unit_t hi;
      u8u16_pkg::unit_t lo;
      if (cp < u8u16_pkg::SUPP_BASE) begin
        expected_words.push_back({cp[15:0], 1'b1});
      end else begin
        offset = cp - u8u16_pkg::SUPP_BASE;
        hi = u8u16_pkg::SURR_HI_BASE + {5'b0, offset[20:10]};
        lo = u8u16_pkg::SURR_LO_BASE + {6'b0, offset[9:0] & u8u16_pkg::SURR_LO_MASK};
        expected_words.push_back({hi, 1'b0});
        expected_words.push_back({lo, 1'b1});
        pairs_seen++;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic taken;
      taken = 1'b0;
      if (conts_left != 2'd0) begin
        if ((b & u8u16_pkg::CONT_MASK) == u8u16_pkg::CONT_TAG) begin
          partial_cp = {partial_cp[14:0], b[5:0]};
          conts_left = conts_left - 2'd1;
          if (conts_left == 2'd0) begin
            queue_codepoint(partial_cp);
            partial_cp = '0;
          end
          taken = 1'b1;
        end else begin
          // broken sequence: drop the pending bits, redo this byte as a lead
          partial_cp = '0;
          conts_left = 2'd0;
        end
      end
      if (!taken) begin
        casez (b)
          8'b0???????: queue_codepoint({13'b0, b});
          8'b110?????: begin
            partial_cp = {16'b0, b[4:0]};
            conts_left = 2'd1;
          end
          8'b1110????: begin
            partial_cp = {17'b0, b[3:0]};
            conts_left = 2'd2;
          end
          8'b11110???: begin
            partial_cp = {18'b0, b[2:0]};
            conts_left = 2'd3;
          end
          default: ; // stray continuation or invalid lead: nothing comes out
        endcase
      end
      if (last && conts_left != 2'd0) begin
        partial_cp = '0;
        conts_left = 2'd0;
        cut_by_end++;
      end
    endfunction

    function void check_word(u8u16_pkg::unit_t unit, logic last);
      utf16_word_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("[%0t] unexpected word: code_unit=%h last_of_run=%b", $time, unit, last);
      end else begin
        want = expected_words.pop_front();
        if (want.unit !== unit || want.last !== last) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("[%0t] word mismatch: code_unit exp %h got %h, last_of_run exp %b got %b",
                     $time, want.unit, unit, want.last, last);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic [7:0]  byte_in   = 8'h00;
  logic        last_byte = 1'b0;
  logic        pop       = 1'b0;
  logic        full;
  logic        empty;
  logic [15:0] code_unit;
  logic        last_of_run;

  utf16_scoreboard sb = new();

  bit idle_on           = 1'b1; // random gaps on both sides
  bit long_hold_request = 1'b0; // picked up by the word sink
  int bytes_sent        = 0;
  int stuck_cycles      = 0;

  utf8_to_utf16_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .byte_in    (byte_in),
    .last_byte  (last_byte),
    .pop        (pop),
    .empty      (empty),
    .code_unit  (code_unit),
    .last_of_run(last_of_run)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Offer one byte, hold it until the block takes it, then maybe idle a while.
  // push stays high between back-to-back bytes, so it never gets two NBAs in a step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    push      <= 1'b1;
    byte_in   <= b;
    last_byte <= last;
    do @(posedge clk); while (full);
    sb.note_byte(b, last);
    bytes_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // One random sequence: mostly well-formed UTF-8 with random payload bits,
  // the rest truncated sequences, raw random bytes, stray continuations
  // and invalid leads.
  task automatic send_sequence();
    int         kind;
    int         len;
    int         n_cont;
    logic [7:0] lead;
    logic       end_flag;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, 4);
    case (len)
      1:       lead = 8'($urandom_range(0, 127));
      2:       lead = 8'(LEAD2_BASE + $urandom_range(0, 31));
      3:       lead = 8'(LEAD3_BASE + $urandom_range(0, 15));
      default: lead = 8'(LEAD4_BASE + $urandom_range(0, 7));
    endcase
    if (kind < 7) begin
      n_cont   = len - 1;
      end_flag = ($urandom_range(0, 7) == 0);
    end else if (kind == 7) begin
      // cut short; the next lead or end of string discards it
      n_cont   = (len > 1) ? $urandom_range(0, len - 2) : 0;
      end_flag = ($urandom_range(0, 2) == 0);
    end else if (kind == 8) begin
      lead     = 8'($urandom_range(0, 255));
      n_cont   = 0;
      end_flag = ($urandom_range(0, 1) == 1);
    end else begin
      lead     = $urandom_range(0, 1) ? 8'(BAD_LEAD + $urandom_range(0, 7))
                                      : 8'(u8u16_pkg::CONT_TAG + $urandom_range(0, 63));
      n_cont   = 0;
      end_flag = ($urandom_range(0, 1) == 1);
    end
    send_byte(lead, (n_cont == 0) ? end_flag : 1'b0);
    for (int i = 1; i <= n_cont; i++)
      send_byte(8'(u8u16_pkg::CONT_TAG + $urandom_range(0, 63)),
                (i == n_cont) ? end_flag : 1'b0);
  endtask

  // Word sink: checks every accepted word, stalls in random bursts,
  // and once sits out a long stretch so the block fills and raises full.
  initial begin : word_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty)
        sb.check_word(code_unit, last_of_run);
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end else if (hold_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 13);
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: no handshake on either side for too long means the block hung.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d still expected",
                 WATCHDOG_LIMIT, sb.expected_words.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and every byte class
    send_byte(8'h00, 1'b0);                         // smallest ASCII
    send_byte(8'h7F, 1'b1);                         // largest ASCII, end of string
    send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0); // two-byte form
    send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0); // overlong NUL passes through
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); // first supplementary: D800 DC00
    send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); // all ones: top of 21-bit range
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
    send_byte(8'hBF, 1'b0);                         // stray continuation
    send_byte(8'hF8, 1'b0);                         // invalid leads
    send_byte(8'hFF, 1'b1);
    send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0); // broken by ASCII, 'A' still out
    send_byte(8'hC3, 1'b1);                         // end of string mid-sequence
    send_byte(8'hA9, 1'b0);                         // now a stray
    send_byte(8'hF4, 1'b0); send_byte(8'hE0, 1'b0); // lead breaks lead

    // random: first a long receiver stall while bytes keep coming
    long_hold_request = 1'b1;
    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent >= RANDOM_BYTES - CALM_TAIL_BYTES)
        idle_on = 1'b0;
      send_sequence();
    end
    push <= 1'b0;

    while (sb.expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes, %0d words checked, %0d surrogate pairs,",
             bytes_sent, sb.words_checked, sb.pairs_seen);
    $display("%0d strings cut mid-sequence, %0d mismatches", sb.cut_by_end, sb.fails);
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
